### src/mcet_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mcet_pkg
// Shared types and fixed-point constants of the minimum cross-entropy
// threshold block.
// ============================================================================
package mcet_pkg;

   // Fixed-point formats: pmf Q1.24, moments Q8.24, logs Q8.16.
   localparam int FRAC_BITS  = 24;
   localparam int PMF_BITS   = 25;
   localparam int MOM_BITS   = 32;
   localparam int LN_BITS    = 24;
   // Bound on |ln m - ln g| in Q8.16, and on (|d|*|l|) >> 16.
   localparam int LDIFF_BITS = 22;
   localparam int TERM_BITS  = 38;
   localparam int COST_BITS  = 48;
   localparam int SQ_STEPS   = 16;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // Input transaction payload.
   typedef struct packed {
      logic [7:0] pixel;
      logic       last;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [8:0] threshold;
      logic       found;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic bin;
      logic clear_step;
      logic compute_init;
      logic idx_zero;
      logic idx_one;
      logic idx_step;
      logic prep_start;
      logic prep_write;
      logic lvl_zero;
      logic lvl_step;
      logic moment_start;
      logic cost_clear;
      logic term_issue;
      logic best_update;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_busy;
      logic loga_busy;
      logic logb_busy;
      logic pipe_busy;
      logic idx_last;
      logic lvl_last;
   } sts_type;

endpackage

### src/mcet_div.sv
`timescale 1ns / 1ps
// ============================================================================
// mcet_div
// Restoring divider that forms floor(h * 2^24 / total), one quotient bit per
// cycle, for a bin count h that never exceeds total.
// ============================================================================
module mcet_div #(
   parameter int COUNT_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [COUNT_BITS-1:0]             dividend,
   input  logic [COUNT_BITS-1:0]             divisor,
   output logic                              busy,
   output logic [mcet_pkg::PMF_BITS-1:0]     quotient
);

   localparam int CNT_BITS = $clog2(mcet_pkg::PMF_BITS);

   logic                          busy_ff, busy_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic [COUNT_BITS:0]           rem_ff, rem_in;
   logic [COUNT_BITS-1:0]         div_ff, div_in;
   logic [mcet_pkg::PMF_BITS-1:0] quo_ff, quo_in;

   logic                          ge;
   logic [COUNT_BITS:0]           diff;

   // One compare and subtract per cycle.
   always_comb begin
      ge      = rem_ff >= {1'b0, div_ff};
      diff    = ge ? rem_ff - {1'b0, div_ff} : rem_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, dividend};
         div_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[mcet_pkg::PMF_BITS-2:0], ge};
         rem_in = {diff[COUNT_BITS-1:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(mcet_pkg::PMF_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### src/mcet_log.sv
`timescale 1ns / 1ps
// ============================================================================
// mcet_log
// Natural log of a Q8.24 value in Q8.16: normalize in five binary steps,
// sixteen squarings for the fraction of log2, then scale by ln 2.
// ============================================================================
module mcet_log (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [mcet_pkg::MOM_BITS-1:0]          x,
   output logic                                   busy,
   output logic signed [mcet_pkg::LN_BITS-1:0]    result
);

   typedef enum logic [2:0] {
      L_IDLE,
      L_NORM,
      L_SQUARE,
      L_SCALE,
      L_ROUND
   } log_state_type;

   log_state_type                      state_ff, state_in;
   logic [31:0]                        m_ff, m_in;
   logic [4:0]                         shift_ff, shift_in;
   logic [3:0]                         step_ff, step_in;
   logic [15:0]                        frac_ff, frac_in;
   logic [53:0]                        prod_ff, prod_in;
   logic                               neg_ff, neg_in;
   logic signed [mcet_pkg::LN_BITS-1:0] result_ff, result_in;

   logic [63:0]        sq;
   logic [32:0]        sh;
   logic signed [5:0]  int_part;
   logic signed [21:0] l2;
   logic [21:0]        mag;
   logic [53:0]        rounded;
   logic [21:0]        r;

   always_comb begin
      sq       = 64'(m_ff) * 64'(m_ff);
      sh       = sq[63:31];
      int_part = 6'sd7 - $signed({1'b0, shift_ff});
      l2       = {int_part, frac_ff};
      mag      = l2[21] ? 22'(-l2) : 22'(l2);
      rounded  = prod_ff + 54'(64'h8000_0000);
      r        = rounded[53:32];

      state_in  = state_ff;
      m_in      = m_ff;
      shift_in  = shift_ff;
      step_in   = step_ff;
      frac_in   = frac_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      result_in = result_ff;

      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               if (x == '0) begin
                  result_in = '0;
               end else begin
                  m_in     = x;
                  shift_in = '0;
                  step_in  = '0;
                  state_in = L_NORM;
               end
            end
         end
         // Shift the leading one up to bit 31, 16/8/4/2/1 places at a time.
         L_NORM: begin
            case (step_ff)
               4'd0: if (m_ff[31:16] == '0) begin
                  m_in = {m_ff[15:0], 16'h0}; shift_in = shift_ff + 5'd16;
               end
               4'd1: if (m_ff[31:24] == '0) begin
                  m_in = {m_ff[23:0], 8'h0}; shift_in = shift_ff + 5'd8;
               end
               4'd2: if (m_ff[31:28] == '0) begin
                  m_in = {m_ff[27:0], 4'h0}; shift_in = shift_ff + 5'd4;
               end
               4'd3: if (m_ff[31:30] == '0) begin
                  m_in = {m_ff[29:0], 2'h0}; shift_in = shift_ff + 5'd2;
               end
               4'd4: if (m_ff[31] == 1'b0) begin
                  m_in = {m_ff[30:0], 1'b0}; shift_in = shift_ff + 5'd1;
               end
               default: begin
               end
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd4) begin
               step_in  = '0;
               frac_in  = '0;
               state_in = L_SQUARE;
            end
         end
         // Each squaring yields one fraction bit of log2.
         L_SQUARE: begin
            frac_in = {frac_ff[14:0], sh[32]};
            m_in    = sh[32] ? sh[32:1] : sh[31:0];
            step_in = step_ff + 1'b1;
            if (step_ff == 4'(mcet_pkg::SQ_STEPS - 1)) begin
               state_in = L_SCALE;
            end
         end
         L_SCALE: begin
            neg_in   = l2[21];
            prod_in  = 54'(mag) * 54'(mcet_pkg::LN2_Q32);
            state_in = L_ROUND;
         end
         L_ROUND: begin
            result_in = neg_ff ? -$signed({2'b00, r}) : $signed({2'b00, r});
            state_in  = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= L_IDLE;
         result_ff <= '0;
      end else begin
         state_ff  <= state_in;
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      shift_ff <= shift_in;
      step_ff  <= step_in;
      frac_ff  <= frac_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
   end

   assign busy   = state_ff != L_IDLE;
   assign result = result_ff;

endmodule

### src/mcet_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// mcet_datapath
// Histogram, pmf, moment and log memories, the shared divider and log units,
// the cost term pipeline and the best-level tracking.
// ============================================================================
module mcet_datapath #(
   parameter int GRAY_LEVELS = 256,
   parameter int COUNT_BITS  = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic [7:0]          req_pixel,
   input  mcet_pkg::cmd_type   cmd,
   output mcet_pkg::sts_type   sts,
   output mcet_pkg::rsp_type   rsp_data
);

   localparam int LB = (GRAY_LEVELS > 1) ? $clog2(GRAY_LEVELS) : 1;
   localparam logic [LB-1:0]         TOP_LEVEL = LB'(GRAY_LEVELS - 1);
   localparam logic [7:0]            TOP_PIXEL = 8'(GRAY_LEVELS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam int MB = mcet_pkg::MOM_BITS;
   localparam int PB = mcet_pkg::PMF_BITS;
   localparam int NB = mcet_pkg::LN_BITS;
   localparam int CB = mcet_pkg::COST_BITS;
   localparam int TB = mcet_pkg::TERM_BITS;
   localparam int DB = mcet_pkg::LDIFF_BITS;

   // Configuration register.
   logic invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b0;
      end else if (csr_wr_en) begin
         invert_ff <= csr_wr_data;
      end
   end

   // Clamp and optional inversion of the incoming pixel.
   logic [7:0]    pix_clamped;
   logic [LB-1:0] level_raw, level_in;

   always_comb begin
      pix_clamped = (req_pixel > TOP_PIXEL) ? TOP_PIXEL : req_pixel;
      level_raw   = pix_clamped[LB-1:0];
      level_in    = invert_ff ? TOP_LEVEL - level_raw : level_raw;
   end

   // Index and level counters.
   logic [LB-1:0] idx_ff, lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         lvl_ff <= '0;
      end else begin
         if (cmd.idx_zero) begin
            idx_ff <= '0;
         end else if (cmd.idx_one) begin
            idx_ff <= LB'(1);
         end else if (cmd.idx_step) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.lvl_zero) begin
            lvl_ff <= '0;
         end else if (cmd.lvl_step) begin
            lvl_ff <= lvl_ff + 1'b1;
         end
      end
   end

   // Histogram memory with a one-deep forward for back-to-back pixels.
   logic [COUNT_BITS-1:0] hist_mem [GRAY_LEVELS];
   logic [COUNT_BITS-1:0] hist_rd_ff;
   logic [LB-1:0]         hist_raddr;
   logic                  bin_v_ff, wr_v_ff;
   logic [LB-1:0]         bin_addr_ff, wr_addr_ff;
   logic [COUNT_BITS-1:0] wr_val_ff, bin_old, bin_new;
   logic [COUNT_BITS-1:0] total_ff;

   always_comb begin
      hist_raddr = cmd.bin ? level_in : idx_ff;
      bin_old    = (wr_v_ff && wr_addr_ff == bin_addr_ff) ? wr_val_ff : hist_rd_ff;
      bin_new    = (bin_old == COUNT_MAX) ? bin_old : bin_old + 1'b1;
   end

   always_ff @(posedge clock) begin
      hist_rd_ff <= hist_mem[hist_raddr];
      if (bin_v_ff) begin
         hist_mem[bin_addr_ff] <= bin_new;
      end else if (cmd.clear_step) begin
         hist_mem[idx_ff] <= '0;
      end
      bin_addr_ff <= level_in;
      wr_addr_ff  <= bin_addr_ff;
      wr_val_ff   <= bin_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_v_ff <= 1'b0;
         wr_v_ff  <= 1'b0;
         total_ff <= '0;
      end else begin
         bin_v_ff <= cmd.bin;
         wr_v_ff  <= bin_v_ff;
         if (cmd.clear_step) begin
            total_ff <= '0;
         end else if (cmd.bin && total_ff != COUNT_MAX) begin
            total_ff <= total_ff + 1'b1;
         end
      end
   end

   // Shared divider and log units.
   logic [PB-1:0]          quotient;
   logic                   div_busy, loga_busy, logb_busy;
   logic signed [NB-1:0]   ln_a, ln_b;
   logic [MB-1:0]          fmom_rd_ff, mom_acc_ff, mb_in, loga_x;
   logic [COUNT_BITS-1:0]  divisor;

   assign divisor = (total_ff == '0) ? COUNT_BITS'(1) : total_ff;
   assign loga_x  = cmd.prep_start ? {8'(idx_ff), {mcet_pkg::FRAC_BITS{1'b0}}} : fmom_rd_ff;
   assign mb_in   = mom_acc_ff - fmom_rd_ff;

   mcet_div #(
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.prep_start),
      .dividend (hist_rd_ff),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   mcet_log u_log_a (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.prep_start | cmd.moment_start),
      .x      (loga_x),
      .busy   (loga_busy),
      .result (ln_a)
   );

   mcet_log u_log_b (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.moment_start),
      .x      (mb_in),
      .busy   (logb_busy),
      .result (ln_b)
   );

   // Per-level tables: pmf, cumulative moment and ln of the level.
   logic [PB-1:0]        pmf_mem   [GRAY_LEVELS];
   logic [MB-1:0]        fmom_mem  [GRAY_LEVELS];
   logic signed [NB-1:0] lnlev_mem [GRAY_LEVELS];
   logic [PB-1:0]        pmf_rd_ff;
   logic signed [NB-1:0] lnlev_rd_ff;
   logic [MB-1:0]        mom_sum;

   assign mom_sum = mom_acc_ff + MB'(idx_ff) * MB'(quotient);

   always_ff @(posedge clock) begin
      if (cmd.prep_write) begin
         pmf_mem[idx_ff]   <= quotient;
         fmom_mem[idx_ff]  <= mom_sum;
         lnlev_mem[idx_ff] <= ln_a;
      end
      pmf_rd_ff   <= pmf_mem[idx_ff];
      lnlev_rd_ff <= lnlev_mem[idx_ff];
      fmom_rd_ff  <= fmom_mem[lvl_ff];
   end

   // Running moment sum and the two moments of the current level.
   logic [MB-1:0] mf_ff, mb_ff;

   always_ff @(posedge clock) begin
      if (cmd.compute_init) begin
         mom_acc_ff <= '0;
      end else if (cmd.prep_write) begin
         mom_acc_ff <= mom_sum;
      end
      if (cmd.moment_start) begin
         mf_ff <= fmom_rd_ff;
         mb_ff <= mb_in;
      end
   end

   // Cost term pipeline, stage 1: difference and log difference.
   logic                 s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic [LB-1:0]        s1_g_ff;
   logic                 s1_f_ff;
   logic [MB-1:0]        s1_m;
   logic signed [NB-1:0] s1_lnm;
   logic signed [MB:0]   s1_d, s1_dn;
   logic signed [NB:0]   s1_l, s1_ln;
   logic [MB-1:0]        s2_ad_ff;
   logic [DB-1:0]        s2_al_ff;
   logic [PB-1:0]        s2_p_ff, s3_p_ff;
   logic                 s2_neg_ff, s3_neg_ff, s4_neg_ff, s5_neg_ff;
   logic [TB-1:0]        s3_t_ff;
   logic [53:0]          s2_prod;
   logic [56:0]          s3_pl;
   logic [30:0]          s3_ph;
   logic [56:0]          s4_pl_ff;
   logic [30:0]          s4_ph_ff;
   logic [62:0]          s4_full;
   logic [38:0]          s5_mag_ff;
   logic signed [CB-1:0] cost_ff, s5_term;

   always_comb begin
      s1_m    = s1_f_ff ? mf_ff : mb_ff;
      s1_lnm  = s1_f_ff ? ln_a : ln_b;
      s1_d    = $signed({1'b0, s1_m}) -
                $signed({1'b0, 8'(s1_g_ff), {mcet_pkg::FRAC_BITS{1'b0}}});
      s1_dn   = -s1_d;
      s1_l    = $signed({s1_lnm[NB-1], s1_lnm}) - $signed({lnlev_rd_ff[NB-1], lnlev_rd_ff});
      s1_ln   = -s1_l;
      s2_prod = 54'(s2_ad_ff) * 54'(s2_al_ff);
      s3_pl   = 57'(s3_t_ff[31:0]) * 57'(s3_p_ff);
      s3_ph   = 31'(s3_t_ff[TB-1:32]) * 31'(s3_p_ff);
      s4_full = {s4_ph_ff, 32'h0} + 63'(s4_pl_ff);
      s5_term = s5_neg_ff ? -$signed(CB'(s5_mag_ff)) : $signed(CB'(s5_mag_ff));
   end

   always_ff @(posedge clock) begin
      s1_g_ff   <= idx_ff;
      s1_f_ff   <= idx_ff <= lvl_ff;
      // Stage 2 operands: magnitudes and the product sign.
      s2_ad_ff  <= s1_d[MB] ? s1_dn[MB-1:0] : s1_d[MB-1:0];
      s2_al_ff  <= s1_l[NB] ? s1_ln[DB-1:0] : s1_l[DB-1:0];
      s2_neg_ff <= s1_d[MB] ^ s1_l[NB];
      s2_p_ff   <= pmf_rd_ff;
      // Stage 3: (|d| * |l|) >> 16.
      s3_t_ff   <= s2_prod[53:16];
      s3_p_ff   <= s2_p_ff;
      s3_neg_ff <= s2_neg_ff;
      // Stage 4: the product with p in two partial products.
      s4_pl_ff  <= s3_pl;
      s4_ph_ff  <= s3_ph;
      s4_neg_ff <= s3_neg_ff;
      // Stage 5: recombine and drop 24 fraction bits.
      s5_mag_ff <= s4_full[62:24];
      s5_neg_ff <= s4_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         cost_ff <= '0;
      end else begin
         s1_v_ff <= cmd.term_issue;
         // A term whose moment is zero counts as zero.
         s2_v_ff <= s1_v_ff && s1_m != '0;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         if (cmd.cost_clear) begin
            cost_ff <= '0;
         end else if (s5_v_ff) begin
            cost_ff <= cost_ff + s5_term;
         end
      end
   end

   // Best level: the first strict minimum among levels with both moments nonzero.
   logic signed [CB-1:0] best_cost_ff;
   logic [LB-1:0]        best_level_ff;
   logic                 best_valid_ff;
   mcet_pkg::rsp_type    rsp_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.compute_init) begin
         best_cost_ff  <= '0;
         best_level_ff <= '0;
         best_valid_ff <= 1'b0;
      end else if (cmd.best_update && mf_ff != '0 && mb_ff != '0 &&
                   (!best_valid_ff || cost_ff < best_cost_ff)) begin
         best_cost_ff  <= cost_ff;
         best_level_ff <= lvl_ff;
         best_valid_ff <= 1'b1;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.threshold <= best_valid_ff ? 9'(best_level_ff) + 9'd1 : 9'd1;
         rsp_ff.found     <= best_valid_ff;
      end
   end

   assign rsp_data      = rsp_ff;
   assign sts.div_busy  = div_busy;
   assign sts.loga_busy = loga_busy;
   assign sts.logb_busy = logb_busy;
   assign sts.pipe_busy = s1_v_ff | s2_v_ff | s3_v_ff | s4_v_ff | s5_v_ff;
   assign sts.idx_last  = idx_ff == TOP_LEVEL;
   assign sts.lvl_last  = lvl_ff == TOP_LEVEL;

endmodule

### src/mcet_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// mcet_ctrl
// Controller: pixel intake, histogram clearing, the per-level preparation,
// the threshold search and the result handshake.
// ============================================================================
module mcet_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  mcet_pkg::sts_type sts,
   output mcet_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DRAIN,
      S_PREP_RD,
      S_PREP_START,
      S_PREP_WAIT,
      S_MOM_RD,
      S_MOM_LOG,
      S_MOM_WAIT,
      S_TERMS,
      S_TERM_DRAIN,
      S_COMPARE,
      S_EMIT
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Next state and commands.
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            cmd.idx_step   = 1'b1;
            if (sts.idx_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.bin = 1'b1;
               if (req_last) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            cmd.compute_init = 1'b1;
            cmd.idx_zero     = 1'b1;
            state_in         = S_PREP_RD;
         end
         S_PREP_RD: begin
            state_in = S_PREP_START;
         end
         S_PREP_START: begin
            cmd.prep_start = 1'b1;
            state_in       = S_PREP_WAIT;
         end
         S_PREP_WAIT: begin
            if (!sts.div_busy && !sts.loga_busy) begin
               cmd.prep_write = 1'b1;
               if (sts.idx_last) begin
                  cmd.lvl_zero = 1'b1;
                  state_in     = S_MOM_RD;
               end else begin
                  cmd.idx_step = 1'b1;
                  state_in     = S_PREP_RD;
               end
            end
         end
         S_MOM_RD: begin
            state_in = S_MOM_LOG;
         end
         S_MOM_LOG: begin
            cmd.moment_start = 1'b1;
            state_in         = S_MOM_WAIT;
         end
         S_MOM_WAIT: begin
            if (!sts.loga_busy && !sts.logb_busy) begin
               cmd.cost_clear = 1'b1;
               cmd.idx_one    = 1'b1;
               state_in       = S_TERMS;
            end
         end
         S_TERMS: begin
            cmd.term_issue = 1'b1;
            cmd.idx_step   = 1'b1;
            if (sts.idx_last) begin
               state_in = S_TERM_DRAIN;
            end
         end
         S_TERM_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.best_update = 1'b1;
            if (sts.lvl_last) begin
               state_in = S_EMIT;
            end else begin
               cmd.lvl_step = 1'b1;
               state_in     = S_MOM_RD;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               cmd.idx_zero = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_CLEAR;
            end
         end
      endcase
   end

   // State and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // The best level is judged only once all terms of the level are summed.
   a_update_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.best_update |-> !sts.pipe_busy)
      else $error("best level updated while terms are in flight");

   // A loaded result is offered in the next cycle.
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result loaded but not offered");

   // Table entries are written only from finished unit results.
   a_prep_done: assert property (@(posedge clock) disable iff (reset)
      cmd.prep_write |-> (!sts.div_busy && !sts.loga_busy))
      else $error("table written while a unit is busy");

endmodule

### src/min_cross_entropy_threshold.sv
`timescale 1ns / 1ps
// ============================================================================
// min_cross_entropy_threshold
// Minimum cross-entropy threshold selection over a stream of gray pixels.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     pixel, last
//   rsp      out        rsp_valid/stall     threshold, found
//   csr      in         csr_wr_en           invert_input
//
// Pixels are binned one per cycle while the block is idle.
// After the pixel marked last, the search is paced by the iterative divider
// and log units and by the single cost term pipeline that handles one level
// g per cycle.
// After reset and after each result a clearing pass empties the histogram;
// no pixel is taken during it or during the search.
// A result waiting under rsp_stall holds the block before the next result is loaded.
// ============================================================================
module min_cross_entropy_threshold #(
   parameter int GRAY_LEVELS = 256,
   parameter int COUNT_BITS  = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  mcet_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mcet_pkg::rsp_type rsp_data
);

   mcet_pkg::cmd_type cmd;
   mcet_pkg::sts_type sts;

   // Controller.
   mcet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath.
   mcet_datapath #(
      .GRAY_LEVELS (GRAY_LEVELS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_pixel   (req_data.pixel),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

endmodule
